/* rtl/ffa_pkg.sv */
// ----------------------------------------------------------------------------
// ffa_pkg
// Shared types and constants for the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int NUM_BLOCKS_DEF   = 1024;
  localparam int MAX_ALLOC_BLOCKS = 255;
  localparam int WORD_BITS        = 8;   // free-map bits per memory word

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_SCAN = 6'b000100,
    S_FLEN = 6'b001000,
    S_MRD  = 6'b010000,
    S_MWR  = 6'b100000
  } state_t;

  // result of one pass of the run search over a free-map word
  typedef struct packed {
    logic       found;
    logic [2:0] off;
    logic [7:0] run;
  } scan_res_t;

endpackage

/* rtl/ffa_run_step.sv */
// ----------------------------------------------------------------------------
// ffa_run_step
// Run-length search over one free-map word, lowest bit first.
// ----------------------------------------------------------------------------
module ffa_run_step (
  input  logic [7:0]        word_i,
  input  logic [7:0]        mask_i,
  input  logic [7:0]        run_i,
  input  logic [7:0]        need_i,
  output ffa_pkg::scan_res_t res_o
);
  import ffa_pkg::*;

  always_comb begin
    logic [7:0] run;
    logic       found;
    logic [2:0] off;
    run   = run_i;
    found = 1'b0;
    off   = 3'd0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (!found) begin
        if (word_i[k] && mask_i[k]) run = run + 8'd1;
        else run = 8'd0;
        if (run == need_i) begin
          found = 1'b1;
          off   = 3'(k);
        end
      end
    end
    res_o.found = found;
    res_o.off   = off;
    res_o.run   = run;
  end

endmodule

/* rtl/first_fit_block_allocator.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit allocator over a one-bit-per-block free map, with per-start
// length records so a free releases the whole allocation.
// ----------------------------------------------------------------------------
//  channel  strobe / accept          payload
//  in       start & !busy            in_operation, in_block_count, in_block_index
//  out      out_valid (one cycle)    out_status, out_start_block
//
//  Allocate: one free-map word (8 blocks) per cycle is searched, then each
//  word touched by the run is read (S_MRD) and then written back (S_MWR).
//  Free: the length record at the index is read (S_FLEN), then each word
//  touched by the allocation is updated in the same way.
//  Bad count or index: result the cycle after acceptance.
//  After reset the free map is set in a pass over every word, busy high.
//  Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int NUM_BLOCKS = ffa_pkg::NUM_BLOCKS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_operation,
  input  logic [7:0] in_block_count,
  input  logic [9:0] in_block_index,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [9:0] out_start_block
);
  import ffa_pkg::*;

  localparam int NW = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW = (NW > 1) ? $clog2(NW) : 1;
  localparam int CW = AW + 1;
  localparam int BW = $clog2(NUM_BLOCKS);
  localparam int PW = $clog2(NW * WORD_BITS + 1);

  logic [7:0] fmap_mem [NW];
  logic [7:0] len_mem  [NUM_BLOCKS];

  state_t     state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] scan_addr_r, scan_addr_nxt;
  logic       rd_vld_r, rd_vld_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0] run_r, run_nxt;
  logic [7:0] need_r, need_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [7:0] rem_r, rem_nxt;
  logic       fill_r, fill_nxt;
  logic [BW-1:0] idx_r, idx_nxt;
  logic [9:0] res_start_r, res_start_nxt;
  logic       out_valid_r, out_valid_nxt;
  status_t    out_status_r, out_status_nxt;
  logic [9:0] out_start_r, out_start_nxt;

  logic [7:0] fmap_rdata_r, len_rdata_r;
  logic       fm_we, len_we;
  logic [AW-1:0] fm_waddr, fm_raddr;
  logic [7:0] fm_wdata, len_wdata;
  logic [BW-1:0] len_waddr, len_raddr;

  logic [7:0] word_mask, bit_mask;
  scan_res_t  step_res;
  logic [PW-1:0] run_start;
  logic [3:0] avail, take;

  always_ff @(posedge clk) begin
    if (fm_we) fmap_mem[fm_waddr] <= fm_wdata;
    fmap_rdata_r <= fmap_mem[fm_raddr];
    if (len_we) len_mem[len_waddr] <= len_wdata;
    len_rdata_r <= len_mem[len_raddr];
  end

  // blocks past the heap end never count as free
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++)
      word_mask[k] = (int'(rd_idx_r) * WORD_BITS + k) < NUM_BLOCKS;
  end

  ffa_run_step u_step (
    .word_i (fmap_rdata_r),
    .mask_i (word_mask),
    .run_i  (run_r),
    .need_i (need_r),
    .res_o  (step_res)
  );

  assign run_start = PW'({rd_idx_r, step_res.off}) + PW'(1) - PW'(need_r);

  // bits of the current word covered by the range being marked
  assign avail = 4'd8 - {1'b0, pos_r[2:0]};
  assign take  = (rem_r < {4'd0, avail}) ? rem_r[3:0] : avail;
  always_comb begin
    for (int k = 0; k < WORD_BITS; k++)
      bit_mask[k] = (4'(k) >= {1'b0, pos_r[2:0]}) &&
                    (4'(k) < ({1'b0, pos_r[2:0]} + take));
  end

  assign fm_raddr  = (state_r == S_SCAN) ? scan_addr_r[AW-1:0] : AW'(pos_r >> 3);
  assign len_raddr = BW'(in_block_index);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    scan_addr_nxt  = scan_addr_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = rd_idx_r;
    run_nxt        = run_r;
    need_nxt       = need_r;
    pos_nxt        = pos_r;
    rem_nxt        = rem_r;
    fill_nxt       = fill_r;
    idx_nxt        = idx_r;
    res_start_nxt  = res_start_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    fm_we          = 1'b0;
    fm_waddr       = AW'(pos_r >> 3);
    fm_wdata       = fill_r ? (fmap_rdata_r | bit_mask) : (fmap_rdata_r & ~bit_mask);
    len_we         = 1'b0;
    len_waddr      = idx_r;
    len_wdata      = 8'd0;

    case (state_r)
      S_CLR: begin
        fm_we    = 1'b1;
        fm_waddr = clr_r;
        fm_wdata = 8'hFF;
        clr_nxt  = clr_r + AW'(1);
        if (clr_r == AW'(NW - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          if (in_operation == OP_FREE) begin
            if (int'(in_block_index) >= NUM_BLOCKS) begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = ST_RANGE;
              out_start_nxt  = 10'd0;
            end else begin
              idx_nxt       = BW'(in_block_index);
              pos_nxt       = PW'(in_block_index);
              fill_nxt      = 1'b1;
              res_start_nxt = 10'd0;
              state_nxt     = S_FLEN;
            end
          end else if (in_block_count == 8'd0 ||
                       int'(in_block_count) > MAX_ALLOC_BLOCKS) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOFIT;
            out_start_nxt  = 10'd0;
          end else begin
            need_nxt      = in_block_count;
            scan_addr_nxt = '0;
            run_nxt       = 8'd0;
            fill_nxt      = 1'b0;
            state_nxt     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // reads issued one word ahead of the search
        if (scan_addr_r < CW'(NW)) begin
          rd_vld_nxt    = 1'b1;
          rd_idx_nxt    = scan_addr_r[AW-1:0];
          scan_addr_nxt = scan_addr_r + CW'(1);
        end
        if (rd_vld_r) begin
          run_nxt = step_res.run;
          if (step_res.found) begin
            rd_vld_nxt    = 1'b0;
            pos_nxt       = run_start;
            rem_nxt       = need_r;
            res_start_nxt = 10'(run_start);
            len_we        = 1'b1;
            len_waddr     = BW'(run_start);
            len_wdata     = need_r;
            state_nxt     = S_MRD;
          end else if (rd_idx_r == AW'(NW - 1)) begin
            rd_vld_nxt     = 1'b0;
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOFIT;
            out_start_nxt  = 10'd0;
            state_nxt      = S_IDLE;
          end
        end
      end
      S_FLEN: begin
        rem_nxt   = len_rdata_r;
        len_we    = 1'b1;
        len_waddr = idx_r;
        state_nxt = S_MRD;
      end
      S_MRD: begin
        if (rem_r == 8'd0 || int'(pos_r) >= NUM_BLOCKS) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_start_nxt  = res_start_r;
          state_nxt      = S_IDLE;
        end else begin
          state_nxt = S_MWR;
        end
      end
      S_MWR: begin
        fm_we     = 1'b1;
        pos_nxt   = {pos_r[PW-1:3] + (PW-3)'(1), 3'b000};
        rem_nxt   = rem_r - {4'd0, take};
        state_nxt = S_MRD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_addr_r  <= scan_addr_nxt;
    rd_idx_r     <= rd_idx_nxt;
    run_r        <= run_nxt;
    need_r       <= need_nxt;
    pos_r        <= pos_nxt;
    rem_r        <= rem_nxt;
    fill_r       <= fill_nxt;
    idx_r        <= idx_nxt;
    res_start_r  <= res_start_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_start_block = out_start_r;

endmodule

/* rtl/ffa_checker.sv */
// ----------------------------------------------------------------------------
// ffa_checker
// Port-level checks for the first-fit block allocator.
// ----------------------------------------------------------------------------
module ffa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       in_operation,
  input logic [7:0] in_block_count,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [9:0] out_start_block
);
  import ffa_pkg::*;

  // a result always closes the item, so the block is free again
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");

  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid)) else $error("item dropped");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> out_start_block == 10'd0)
    else $error("failure with start block");

  a_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_NOFIT ||
                   out_status == ST_RANGE)) else $error("bad status");

  a_zero_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == OP_ALLOC && in_block_count == 8'd0)
    |=> (out_valid && out_status == ST_NOFIT)) else $error("zero count");

endmodule

bind first_fit_block_allocator ffa_checker u_ffa_checker (.*);
